// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rsnh_pkg.sv =====
// ----------------------------------------------------------------------------
// rsnh_pkg
// Shared types, constants and step codes of the nearest-hit ray caster.
// ----------------------------------------------------------------------------
package rsnh_pkg;

  localparam int MAX_SEGMENTS    = 256;
  localparam int COORD_FRAC_BITS = 16;
  localparam int IDX_W           = $clog2(MAX_SEGMENTS);
  localparam int CNT_W           = $clog2(MAX_SEGMENTS + 1);
  localparam int RANGE_W         = 31;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 32;

  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(500 << COORD_FRAC_BITS);
  localparam logic [CNT_W-1:0]   CNT_MAX     = CNT_W'(MAX_SEGMENTS);

  localparam logic [CFG_IDX_W-1:0] REG_RANGE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  // controller states, also the datapath step codes
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_IDLE = 5'd0;
  localparam logic [STEP_W-1:0] ST_READ = 5'd1;
  localparam logic [STEP_W-1:0] ST_DIFF = 5'd2;
  localparam logic [STEP_W-1:0] ST_M0   = 5'd3;
  localparam logic [STEP_W-1:0] ST_M1   = 5'd4;
  localparam logic [STEP_W-1:0] ST_M2   = 5'd5;
  localparam logic [STEP_W-1:0] ST_M3   = 5'd6;
  localparam logic [STEP_W-1:0] ST_M4   = 5'd7;
  localparam logic [STEP_W-1:0] ST_M5   = 5'd8;
  localparam logic [STEP_W-1:0] ST_M6   = 5'd9;
  localparam logic [STEP_W-1:0] ST_M7   = 5'd10;
  localparam logic [STEP_W-1:0] ST_M8   = 5'd11;
  localparam logic [STEP_W-1:0] ST_T34  = 5'd12;
  localparam logic [STEP_W-1:0] ST_DIV  = 5'd13;
  localparam logic [STEP_W-1:0] ST_OFX  = 5'd14;
  localparam logic [STEP_W-1:0] ST_OFY  = 5'd15;
  localparam logic [STEP_W-1:0] ST_HX   = 5'd16;
  localparam logic [STEP_W-1:0] ST_HY   = 5'd17;
  localparam logic [STEP_W-1:0] ST_SQ1  = 5'd18;
  localparam logic [STEP_W-1:0] ST_SQ2  = 5'd19;
  localparam logic [STEP_W-1:0] ST_SQ3  = 5'd20;
  localparam logic [STEP_W-1:0] ST_SQL  = 5'd21;
  localparam logic [STEP_W-1:0] ST_DM   = 5'd22;
  localparam logic [STEP_W-1:0] ST_DC   = 5'd23;
  localparam logic [STEP_W-1:0] ST_AL1  = 5'd24;
  localparam logic [STEP_W-1:0] ST_AL2  = 5'd25;
  localparam logic [STEP_W-1:0] ST_AL3  = 5'd26;
  localparam logic [STEP_W-1:0] ST_SQA  = 5'd27;
  localparam logic [STEP_W-1:0] ST_UPD  = 5'd28;
  localparam logic [STEP_W-1:0] ST_FIN  = 5'd29;
  // step codes that are no state
  localparam logic [STEP_W-1:0] OPC_LOAD = 5'd30;
  localparam logic [STEP_W-1:0] OPC_INIT = 5'd31;

  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 36;
  localparam int ITER_W     = 6;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [IDX_W-1:0]  addr;
  } dp_cmd_t;

  typedef struct packed {
    logic opp12;
    logic opp34;
    logic closer;
  } dp_status_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic        [3:0]  tex;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] rdx;
    logic signed [31:0] rdy;
    logic        [15:0] vcos;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic [RANGE_W-1:0] distance;
    logic [IDX_W-1:0]   seg;
    logic [3:0]         tex;
    logic [31:0]        along;
  } result_t;

endpackage

// ===== src/ray_segment_nearest_hit.sv =====
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit
// Nearest strict crossing of one ray with a loaded table of wall segments.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_      slave      tuser: op; tdata: seg_index, seg_start_x/y, seg_end_x/y,
//                      seg_texture, origin_x/y, ray_dx/dy, view_cos
//  out_     master     tuser: hit; tdata: distance, hit_segment, hit_texture,
//                      along_offset
//  cfg_     slave      cfg_index, cfg_data (0 range limit, 1 segment_count)
//
//  A load leaves the block ready. A cast walks the table; per tested segment it
//  stops when the first or second sign pair fails, after the compare (hit, not
//  nearer) or after the update (new nearest): the 32-step divider and 36-step
//  square root dominate. The result waits in an output register; a new item is
//  taken meanwhile. rst_n is synchronous; the table is not cleared by reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_segment_nearest_hit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [287:0]                    in_tdata,  // seg_index, seg_start_x, seg_start_y,
                                                     // seg_end_x, seg_end_y, seg_texture,
                                                     // origin_x, origin_y, ray_dx, ray_dy,
                                                     // view_cos, zero pad
  input  logic [0:0]                      in_tuser,  // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [79:0]                     out_tdata, // distance, hit_segment, hit_texture,
                                                     // along_offset, zero pad
  output logic [0:0]                      out_tuser, // hit
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsnh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsnh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rsnh_pkg::*;

  cfg_wr_t    cfg_wr;
  dp_cmd_t    cmd;
  dp_status_t sts;
  item_t      item;
  result_t    result;
  dp_cmd_t    cmd_mux;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign item.sx   = $signed(in_tdata[39:8]);
  assign item.sy   = $signed(in_tdata[71:40]);
  assign item.ex   = $signed(in_tdata[103:72]);
  assign item.ey   = $signed(in_tdata[135:104]);
  assign item.tex  = in_tdata[139:136];
  assign item.ox   = $signed(in_tdata[171:140]);
  assign item.oy   = $signed(in_tdata[203:172]);
  assign item.rdx  = $signed(in_tdata[235:204]);
  assign item.rdy  = $signed(in_tdata[267:236]);
  assign item.vcos = in_tdata[283:268];

  // load slot comes from the item, table walk address from the sequencer
  always_comb begin
    cmd_mux = cmd;
    if (cmd.step == OPC_LOAD) cmd_mux.addr = in_tdata[IDX_W-1:0];
  end

  rsnh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser[0]),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rsnh_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cmd    (cmd_mux),
    .item   (item),
    .sts    (sts),
    .result (result)
  );

  assign out_tuser[0] = result.hit;
  assign out_tdata    = {5'b0, result.along, result.tex, result.seg, result.distance};

  `ASSERT_NXT(a_cast_busy, in_tvalid && in_tready && in_tuser[0] == OP_CAST, !in_tready,
    "cast accepted but input still ready")
  `ASSERT_IMP(a_miss_zero, out_tvalid && !out_tuser[0], out_tdata[74:31] == '0,
    "miss result carries segment, texture or offset")
  `ASSERT_NXT(a_load_idle, in_tvalid && in_tready && in_tuser[0] == OP_LOAD, in_tready,
    "load left the block busy")

endmodule

// ===== src/rsnh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsnh_ctrl
// Sequencer: walks the segment table, steps the datapath, owns the handshakes.
// ----------------------------------------------------------------------------
module rsnh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  rsnh_pkg::cfg_wr_t    cfg_wr,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rsnh_pkg::dp_cmd_t    cmd,
  input  rsnh_pkg::dp_status_t sts
);
  import rsnh_pkg::*;

  logic [STEP_W-1:0] state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  seg_count_r;
  logic [CNT_W-1:0]  cnt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept, fin_go;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign cnt       = (seg_count_r > CNT_MAX) ? CNT_MAX : seg_count_r;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    iter_nxt  = iter_r;
    cmd.addr  = idx_r[IDX_W-1:0];
    cmd.step  = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.step = ST_IDLE;
        if (accept) begin
          if (in_op == OP_CAST) begin
            cmd.step  = OPC_INIT;
            idx_nxt   = '0;
            state_nxt = ST_READ;
          end else begin
            cmd.step = OPC_LOAD;
          end
        end
      end
      ST_READ: state_nxt = (idx_r >= cnt) ? ST_FIN : ST_DIFF;
      ST_DIFF: state_nxt = ST_M0;
      ST_M0:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_M5;
      ST_M5: begin
        if (sts.opp12) begin
          state_nxt = ST_M6;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_M6:   state_nxt = ST_M7;
      ST_M7:   state_nxt = ST_M8;
      ST_M8:   state_nxt = ST_T34;
      ST_T34: begin
        iter_nxt = '0;
        if (sts.opp34) begin
          state_nxt = ST_DIV;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_DIV: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(DIV_STEPS - 1)) state_nxt = ST_OFX;
      end
      ST_OFX:  state_nxt = ST_OFY;
      ST_OFY:  state_nxt = ST_HX;
      ST_HX:   state_nxt = ST_HY;
      ST_HY:   state_nxt = ST_SQ1;
      ST_SQ1:  state_nxt = ST_SQ2;
      ST_SQ2:  state_nxt = ST_SQ3;
      ST_SQ3: begin
        iter_nxt  = '0;
        state_nxt = ST_SQL;
      end
      ST_SQL: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(SQRT_STEPS - 1)) state_nxt = ST_DM;
      end
      ST_DM:   state_nxt = ST_DC;
      ST_DC: begin
        if (sts.closer) begin
          state_nxt = ST_AL1;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_AL1:  state_nxt = ST_AL2;
      ST_AL2:  state_nxt = ST_AL3;
      ST_AL3: begin
        iter_nxt  = '0;
        state_nxt = ST_SQA;
      end
      ST_SQA: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(SQRT_STEPS - 1)) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_READ;
      end
      ST_FIN: begin
        cmd.step = fin_go ? ST_FIN : ST_IDLE;
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = fin_go ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
      seg_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid && cfg_wr.index == REG_COUNT) begin
        seg_count_r <= cfg_wr.data[CNT_W-1:0];
      end
    end
  end

endmodule

// ===== src/rsnh_dp.sv =====
// ----------------------------------------------------------------------------
// rsnh_dp
// Datapath: segment table, shared multiplier, divider and square root steps.
// ----------------------------------------------------------------------------
module rsnh_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  rsnh_pkg::cfg_wr_t    cfg_wr,
  input  rsnh_pkg::dp_cmd_t    cmd,
  input  rsnh_pkg::item_t      item,
  output rsnh_pkg::dp_status_t sts,
  output rsnh_pkg::result_t    result
);
  import rsnh_pkg::*;

  logic [131:0] mem [MAX_SEGMENTS];
  logic [131:0] mem_q_r;

  logic [RANGE_W-1:0] range_r;
  logic signed [31:0] ox_r, oy_r, rdx_r, rdy_r;
  logic        [15:0] vcos_r;

  logic signed [32:0] sx_ox_r, sy_oy_r, ex_ox_r, ey_oy_r, wx_r, wy_r;
  logic signed [33:0] r3_r, r4_r;
  logic        [3:0]  tex_r;

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod_r, acc_r, z1_r, z2_r, z3_r, z4_r;

  logic [69:0] az1, az2;
  logic [70:0] num_r, den_r, num_sh;
  logic [31:0] t_r;

  logic signed [33:0] offx_r, offy_r;
  logic signed [34:0] hx_r, hy_r;
  logic        [32:0] frac_mag;

  logic [71:0] rad_r;
  logic [37:0] rem_r, rem_sh, trial;
  logic [35:0] root_r;

  logic [36:0] dist_now;
  logic [36:0] dist_r;
  logic [69:0] sum_sq;

  logic [RANGE_W-1:0] nearest_r;
  logic               found_r;
  logic [IDX_W-1:0]   best_seg_r;
  logic [3:0]         best_tex_r;
  logic [31:0]        best_along_r;
  result_t            out_r;

  logic signed [31:0] m_sx, m_sy, m_ex, m_ey;

  assign m_sx = $signed(mem_q_r[31:0]);
  assign m_sy = $signed(mem_q_r[63:32]);
  assign m_ex = $signed(mem_q_r[95:64]);
  assign m_ey = $signed(mem_q_r[127:96]);

  function automatic logic opposite(input logic signed [69:0] a, input logic signed [69:0] b);
    opposite = (a != '0) && (b != '0) && (a[69] != b[69]);
  endfunction

  assign sts.opp12 = opposite(z1_r, z2_r);
  assign sts.opp34 = opposite(z3_r, z4_r);

  assign dist_now   = prod_r[51:15];
  assign sts.closer = dist_now < {6'b0, nearest_r};

  assign az1    = z1_r[69] ? 70'(-z1_r) : 70'(z1_r);
  assign az2    = z2_r[69] ? 70'(-z2_r) : 70'(z2_r);
  assign num_sh = {num_r[69:0], 1'b0};

  assign rem_sh = {rem_r[35:0], rad_r[71:70]};
  assign trial  = {root_r, 2'b01};

  assign frac_mag = prod_r[64:32];
  assign sum_sq   = 70'(acc_r + prod_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      ST_M0:  begin mul_a = 35'(rdx_r);    mul_b = 35'(sy_oy_r);  end
      ST_M1:  begin mul_a = 35'(sx_ox_r);  mul_b = 35'(rdy_r);    end
      ST_M2:  begin mul_a = 35'(rdx_r);    mul_b = 35'(ey_oy_r);  end
      ST_M3:  begin mul_a = 35'(ex_ox_r);  mul_b = 35'(rdy_r);    end
      ST_M4:  begin mul_a = 35'(wx_r);     mul_b = 35'(r3_r);     end
      ST_M5:  begin mul_a = 35'(r4_r);     mul_b = 35'(wy_r);     end
      ST_M6:  begin mul_a = 35'(wx_r);     mul_b = -35'(sy_oy_r); end
      ST_M7:  begin mul_a = -35'(sx_ox_r); mul_b = 35'(wy_r);     end
      ST_OFX: begin
        mul_a = wx_r[32] ? -35'(wx_r) : 35'(wx_r);
        mul_b = $signed({3'b0, t_r});
      end
      ST_OFY: begin
        mul_a = wy_r[32] ? -35'(wy_r) : 35'(wy_r);
        mul_b = $signed({3'b0, t_r});
      end
      ST_SQ1: begin mul_a = hx_r; mul_b = hx_r; end
      ST_SQ2: begin mul_a = hy_r; mul_b = hy_r; end
      ST_DM:  begin mul_a = $signed(root_r[34:0]); mul_b = $signed({19'b0, vcos_r}); end
      ST_AL1: begin mul_a = 35'(offx_r); mul_b = 35'(offx_r); end
      ST_AL2: begin mul_a = 35'(offy_r); mul_b = 35'(offy_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.step == OPC_LOAD) begin
      mem[cmd.addr] <= {item.tex, item.ey, item.ex, item.sy, item.sx};
    end
    if (cmd.step == ST_READ) begin
      mem_q_r <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.step)
      OPC_INIT: begin
        ox_r   <= item.ox;
        oy_r   <= item.oy;
        rdx_r  <= item.rdx;
        rdy_r  <= item.rdy;
        vcos_r <= item.vcos;
      end
      ST_DIFF: begin
        sx_ox_r <= 33'(m_sx) - 33'(ox_r);
        sy_oy_r <= 33'(m_sy) - 33'(oy_r);
        ex_ox_r <= 33'(m_ex) - 33'(ox_r);
        ey_oy_r <= 33'(m_ey) - 33'(oy_r);
        wx_r    <= 33'(m_ex) - 33'(m_sx);
        wy_r    <= 33'(m_ey) - 33'(m_sy);
        r3_r    <= 34'(rdy_r) + 34'(oy_r) - 34'(m_sy);
        r4_r    <= 34'(rdx_r) + 34'(ox_r) - 34'(m_sx);
        tex_r   <= mem_q_r[131:128];
      end
      ST_M1, ST_M3, ST_M5, ST_M7, ST_SQ2, ST_AL2: acc_r <= prod_r;
      ST_M2: z1_r <= acc_r - prod_r;
      ST_M4: z2_r <= acc_r - prod_r;
      ST_M6: z3_r <= acc_r - prod_r;
      ST_M8: z4_r <= acc_r - prod_r;
      ST_T34: begin
        num_r <= 71'(az1);
        den_r <= 71'(az1) + 71'(az2);
        t_r   <= '0;
      end
      ST_DIV: begin
        if (num_sh >= den_r) begin
          num_r <= num_sh - den_r;
          t_r   <= {t_r[30:0], 1'b1};
        end else begin
          num_r <= num_sh;
          t_r   <= {t_r[30:0], 1'b0};
        end
      end
      ST_OFY: offx_r <= wx_r[32] ? -34'(frac_mag) : 34'(frac_mag);
      ST_HX: begin
        offy_r <= wy_r[32] ? -34'(frac_mag) : 34'(frac_mag);
        hx_r   <= 35'(sx_ox_r) + 35'(offx_r);
      end
      ST_HY: hy_r <= 35'(sy_oy_r) + 35'(offy_r);
      ST_SQ3, ST_AL3: begin
        rad_r  <= {2'b0, sum_sq};
        rem_r  <= '0;
        root_r <= '0;
      end
      ST_SQL, ST_SQA: begin
        rad_r <= {rad_r[69:0], 2'b0};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[34:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[34:0], 1'b0};
        end
      end
      ST_DC: dist_r <= dist_now;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      OPC_INIT: begin
        nearest_r    <= range_r;
        found_r      <= 1'b0;
        best_seg_r   <= '0;
        best_tex_r   <= '0;
        best_along_r <= '0;
      end
      ST_UPD: begin
        nearest_r    <= dist_r[RANGE_W-1:0];
        found_r      <= 1'b1;
        best_seg_r   <= cmd.addr;
        best_tex_r   <= tex_r;
        best_along_r <= (root_r[35:32] != '0) ? 32'hFFFF_FFFF : root_r[31:0];
      end
      ST_FIN: begin
        out_r.hit      <= found_r;
        out_r.distance <= nearest_r;
        out_r.seg      <= best_seg_r;
        out_r.tex      <= best_tex_r;
        out_r.along    <= best_along_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= RANGE_RESET;
    end else if (cfg_wr.valid && cfg_wr.index == REG_RANGE) begin
      range_r <= cfg_wr.data[RANGE_W-1:0];
    end
  end

  assign result = out_r;

endmodule

// ===== bench/tb_ray_segment_nearest_hit.sv =====
// ----------------------------------------------------------------------------
// tb_ray_segment_nearest_hit
// Loads wall segment tables and casts rays at them, checking every result
// against a cycle-free predictor of the nearest strict crossing.
// ----------------------------------------------------------------------------
module tb_ray_segment_nearest_hit;
  timeunit 1ns;
  timeprecision 1ps;
  import rsnh_pkg::*;

  typedef struct {
    logic       op;
    logic [7:0] idx;
    item_t      f;
  } wall_req_t;

  localparam int  WATCHDOG_LIMIT = 200000;
  localparam int  HOLD_CYCLES    = 1500;
  localparam int  BOX            = 300 << 16;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ray_segment_nearest_hit dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] wall_sx [MAX_SEGMENTS];
  logic signed [31:0] wall_sy [MAX_SEGMENTS];
  logic signed [31:0] wall_ex [MAX_SEGMENTS];
  logic signed [31:0] wall_ey [MAX_SEGMENTS];
  logic [3:0]         wall_tex [MAX_SEGMENTS];
  logic [RANGE_W-1:0] range_reg = RANGE_RESET;
  logic [8:0]         count_reg = '0;

  // generator mirror of the table, used to aim rays
  longint gen_sx [MAX_SEGMENTS];
  longint gen_sy [MAX_SEGMENTS];
  longint gen_ex [MAX_SEGMENTS];
  longint gen_ey [MAX_SEGMENTS];

  wall_req_t pending_items[$];
  result_t   expected_hits[$];
  wall_req_t cur_item;

  int  error_count = 0;
  int  loads_sent = 0, casts_sent = 0, hits_seen = 0, results_seen = 0;
  bit  quiet = 1'b0;
  int  stall_requests = 0, stall_served = 0, hold_cnt = 0;
  int  idle_cycles = 0;

  function automatic logic [71:0] mag72(logic signed [71:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit opposite(logic signed [71:0] a, logic signed [71:0] b);
    return a != 0 && b != 0 && ((a < 0) != (b < 0));
  endfunction

  function automatic logic [35:0] floor_sqrt(logic [71:0] n);
    logic [35:0] r;
    logic [71:0] c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = 72'(r | (36'd1 << b));
      if (c * c <= n) r = c[35:0];
    end
    return r;
  endfunction

  function automatic logic signed [71:0] scale_frac(logic signed [71:0] d, logic [31:0] t);
    logic [103:0] p;
    p = (104'(mag72(d)) * 104'(t)) >> 32;
    return d < 0 ? -$signed(72'(p)) : $signed(72'(p));
  endfunction

  function automatic result_t cast_predict(item_t it);
    result_t r;
    logic signed [71:0] ox, oy, rdx, rdy, sx, sy, ex, ey, wx, wy;
    logic signed [71:0] z1, z2, z3, z4, offx, offy, hx, hy;
    logic [71:0]  num, den;
    logic [103:0] quo;
    logic [31:0]  t;
    logic [35:0]  len, al;
    logic [63:0]  scaled_len, nearest;
    int n;
    ox = 72'(it.ox); oy = 72'(it.oy); rdx = 72'(it.rdx); rdy = 72'(it.rdy);
    nearest = 64'(range_reg);
    r = '0;
    n = count_reg > MAX_SEGMENTS ? MAX_SEGMENTS : int'(count_reg);
    for (int i = 0; i < n; i++) begin
      sx = 72'(wall_sx[i]); sy = 72'(wall_sy[i]);
      ex = 72'(wall_ex[i]); ey = 72'(wall_ey[i]);
      wx = ex - sx; wy = ey - sy;
      z1 = rdx * (sy - oy) - (sx - ox) * rdy;
      z2 = rdx * (ey - oy) - (ex - ox) * rdy;
      if (!opposite(z1, z2)) continue;
      z3 = wx * (rdy + oy - sy) - (rdx + ox - sx) * wy;
      z4 = wx * (oy - sy) - (ox - sx) * wy;
      if (!opposite(z3, z4)) continue;
      num = mag72(z1);
      den = num + mag72(z2);
      quo = (104'(num) << 32) / 104'(den);
      t = quo[31:0];
      offx = scale_frac(wx, t);
      offy = scale_frac(wy, t);
      hx = sx - ox + offx;
      hy = sy - oy + offy;
      len = floor_sqrt(72'(hx * hx + hy * hy));
      scaled_len = (64'(len) * 64'(it.vcos)) >> 15;
      if (scaled_len < nearest) begin
        al = floor_sqrt(72'(offx * offx + offy * offy));
        nearest = scaled_len;
        r.hit = 1'b1;
        r.seg = IDX_W'(i);
        r.tex = wall_tex[i];
        r.along = al > 36'hFFFFFFFF ? 32'hFFFFFFFF : al[31:0];
      end
    end
    r.distance = nearest[RANGE_W-1:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, results_seen);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur_item.op == OP_LOAD) begin
          wall_sx[cur_item.idx] = cur_item.f.sx;
          wall_sy[cur_item.idx] = cur_item.f.sy;
          wall_ex[cur_item.idx] = cur_item.f.ex;
          wall_ey[cur_item.idx] = cur_item.f.ey;
          wall_tex[cur_item.idx] = cur_item.f.tex;
          loads_sent++;
        end else begin
          expected_hits.push_back(cast_predict(cur_item.f));
          casts_sent++;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
          cur_item = pending_items.pop_front();
          in_tdata <= {4'b0, cur_item.f.vcos, cur_item.f.rdy, cur_item.f.rdx, cur_item.f.oy,
                       cur_item.f.ox, cur_item.f.tex, cur_item.f.ey, cur_item.f.ex,
                       cur_item.f.sy, cur_item.f.sx, cur_item.idx};
          in_tuser <= cur_item.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser[0]) hits_seen++;
        if (expected_hits.size() == 0) begin
          report("unexpected result", 64'(out_tdata[30:0]), 64'(0));
        end else begin
          want = expected_hits.pop_front();
          if (out_tuser[0] !== want.hit)
            report("hit", 64'(out_tuser[0]), 64'(want.hit));
          if (out_tdata[30:0] !== want.distance)
            report("distance", 64'(out_tdata[30:0]), 64'(want.distance));
          if (out_tdata[38:31] !== want.seg)
            report("hit_segment", 64'(out_tdata[38:31]), 64'(want.seg));
          if (out_tdata[42:39] !== want.tex)
            report("hit_texture", 64'(out_tdata[42:39]), 64'(want.tex));
          if (out_tdata[74:43] !== want.along)
            report("along_offset", 64'(out_tdata[74:43]), 64'(want.along));
        end
      end
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || $urandom_range(99) >= 18;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic settle();
    while (pending_items.size() > 0 || in_tvalid || expected_hits.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    settle();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_RANGE) range_reg = val[RANGE_W-1:0];
    else if (idx == REG_COUNT) count_reg = val[8:0];
  endtask

  task automatic add_load(logic [7:0] idx, int sx, int sy, int ex, int ey, logic [3:0] tex);
    wall_req_t w;
    w.op = OP_LOAD; w.idx = idx; w.f = '0;
    w.f.sx = sx; w.f.sy = sy; w.f.ex = ex; w.f.ey = ey; w.f.tex = tex;
    w.f.ox = $urandom; w.f.oy = $urandom; w.f.rdx = $urandom; w.f.rdy = $urandom;
    w.f.vcos = 16'($urandom);
    gen_sx[idx] = sx; gen_sy[idx] = sy; gen_ex[idx] = ex; gen_ey[idx] = ey;
    pending_items.push_back(w);
  endtask

  task automatic add_cast(int ox, int oy, int dx, int dy, logic [15:0] vcos);
    wall_req_t w;
    w.op = OP_CAST; w.idx = 8'($urandom); w.f = '0;
    w.f.sx = $urandom; w.f.sy = $urandom; w.f.ex = $urandom; w.f.ey = $urandom;
    w.f.tex = 4'($urandom);
    w.f.ox = ox; w.f.oy = oy; w.f.rdx = dx; w.f.rdy = dy; w.f.vcos = vcos;
    pending_items.push_back(w);
  endtask

  function automatic int box_coord();
    return int'(longint'($urandom_range(2 * BOX)) - BOX);
  endfunction

  task automatic random_load(logic [7:0] idx);
    if ($urandom_range(99) < 15)
      add_load(idx, $urandom, $urandom, $urandom, $urandom, 4'($urandom));
    else
      add_load(idx, box_coord(), box_coord(), box_coord(), box_coord(), 4'($urandom));
  endtask

  task automatic random_cast();
    int n, j, k;
    longint f, tx, ty, ox, oy;
    logic [15:0] vc;
    n = count_reg > MAX_SEGMENTS ? MAX_SEGMENTS : int'(count_reg);
    vc = $urandom_range(99) < 10 ? 16'($urandom) : 16'($urandom_range(32768, 16000));
    if (n == 0 || $urandom_range(99) < 20) begin
      add_cast($urandom, $urandom, $urandom, $urandom, 16'($urandom));
    end else begin
      j = $urandom_range(n - 1);
      f = $urandom_range(255, 1);
      tx = gen_sx[j] + (gen_ex[j] - gen_sx[j]) * f / 256;
      ty = gen_sy[j] + (gen_ey[j] - gen_sy[j]) * f / 256;
      ox = box_coord();
      oy = box_coord();
      k = $urandom_range(16, 5);
      add_cast(int'(ox), int'(oy), int'((tx - ox) * k / 8), int'((ty - oy) * k / 8), vc);
    end
  endtask

  task automatic random_phase(int items);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 25) random_load(8'($urandom_range(MAX_SEGMENTS - 1)));
      else random_cast();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, empty table walk
    add_cast(0, 0, 100 << 16, 0, 16'd32768);
    write_reg(REG_COUNT, 5);
    add_load(0, 10 << 16, -(10 << 16), 10 << 16, 10 << 16, 4'd0);
    add_load(1, 5 << 16, -(10 << 16), 5 << 16, 10 << 16, 4'd15);
    add_load(2, 5 << 16, -(10 << 16), 5 << 16, 10 << 16, 4'd7);
    add_load(3, 1 << 16, 0, 50 << 16, 0, 4'd3);
    add_load(4, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 4'd9);
    add_cast(0, 0, 100 << 16, 0, 16'd32768);
    add_cast(0, 0, 5 << 16, 0, 16'd32768);
    add_cast(0, 0, 100 << 16, 0, 16'd0);
    add_cast(0, 0, 100 << 16, 0, 16'hFFFF);
    add_cast(0, 1 << 15, 100 << 16, 0, 16'd23170);
    add_cast(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'd32768);
    add_cast(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 16'd32768);
    add_cast(0, 0, 32'sh80000000, 32'sh80000000, 16'd32768);
    write_reg(REG_RANGE, 32'hFFFFFFFF);
    add_cast(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'hFFFF);
    add_cast(-(20 << 16), 0, 32'sh7FFFFFFF, 0, 16'd32768);
    write_reg(REG_RANGE, 32'h80000000 | (500 << 16));

    // fill the whole table with casts against the first slots in between
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      random_load(8'(i));
      if (i % 3 == 0) random_cast();
    end

    write_reg(REG_RANGE, 32'h7FFFFFFF);
    write_reg(REG_COUNT, 8);
    random_phase(120);

    write_reg(REG_RANGE, 32'(RANGE_RESET));
    write_reg(REG_COUNT, 1);
    settle();
    quiet = 1'b1;
    random_phase(100);
    settle();
    quiet = 1'b0;

    write_reg(REG_RANGE, $urandom_range(32'h7FFFFFFF, 100 << 16));
    write_reg(REG_COUNT, 16);
    stall_requests++;
    random_phase(120);

    write_reg(REG_RANGE, 0);
    write_reg(REG_COUNT, 3);
    random_phase(60);

    write_reg(REG_RANGE, 32'h7FFFFFFF);
    write_reg(REG_COUNT, MAX_SEGMENTS);
    for (int i = 0; i < 6; i++) random_cast();
    write_reg(REG_COUNT, 300);
    for (int i = 0; i < 5; i++) random_cast();
    write_reg(REG_COUNT, 511);
    for (int i = 0; i < 4; i++) random_cast();
    write_reg(REG_COUNT, 0);
    random_phase(40);

    write_reg(4'd7, 32'hFFFFFFFF);
    write_reg(REG_RANGE, 40 << 16);
    write_reg(REG_COUNT, 6);
    write_reg(4'hF, 0);
    random_phase(120);

    write_reg(REG_RANGE, 32'(RANGE_RESET));
    write_reg(REG_COUNT, 12);
    stall_requests++;
    random_phase(120);

    write_reg(REG_RANGE, 1000 << 16);
    write_reg(REG_COUNT, $urandom_range(10, 2));
    random_phase(120);

    settle();
    repeat (200) @(posedge clk);
    $display("covered %0d loads and %0d casts, %0d results with %0d hits",
             loads_sent, casts_sent, results_seen, hits_seen);
    $display("segment counts from zero to beyond the table, ranges from zero to maximum");
    if (error_count == 0 && expected_hits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_hits.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
